FILE: hdl/ntc_table_temperature_macros.svh
// ----------------------------------------------------------------------------
// NTC table temperature assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NTC_TABLE_TEMPERATURE_MACROS_SVH
`define NTC_TABLE_TEMPERATURE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define NTCT_ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ntc_table_temperature: property violated");
`define NTCT_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ntc_table_temperature: forbidden condition seen");
`else
`define NTCT_ASSERT_PROP(label, prop)
`define NTCT_ASSERT_NEVER(label, cond)
`endif

`endif

FILE: hdl/ntct_pkg.sv
// ----------------------------------------------------------------------------
// NTC table temperature package
// Widths, calibration table and shared types for the thermistor converter.
// ----------------------------------------------------------------------------
package ntct_pkg;

  localparam int SAMPLE_W           = 10;
  localparam int SUM_W              = 16;
  localparam int TEMP_W             = 12;
  localparam int SAMPLES_PER_RESULT = 64;
  localparam int CNT_W              = $clog2(SAMPLES_PER_RESULT);
  localparam int TABLE_ENTRIES      = 60;
  localparam int IDX_W              = $clog2(TABLE_ENTRIES);

  localparam int TEMP_START = 50;
  localparam int TEMP_STEP  = 50;

  localparam logic [TEMP_W-1:0] TEMP_UNDER = TEMP_W'(0);
  localparam logic [TEMP_W-1:0] TEMP_OVER  = TEMP_W'(3000);

  // The interpolated offset never exceeds one temperature step.
  localparam int Q_W    = $clog2(TEMP_STEP + 1);
  localparam int STEP_W = $clog2(Q_W);
  localparam int NUM_W  = SUM_W + Q_W;
  localparam int UNIT_W = NUM_W;

  localparam logic [SUM_W-1:0] CAL_ROM [TABLE_ENTRIES] = '{
    16'd64478, 16'd64166, 16'd63780, 16'd63307, 16'd62735,
    16'd62050, 16'd61239, 16'd60290, 16'd59193, 16'd57938,
    16'd56521, 16'd54941, 16'd53200, 16'd51308, 16'd49278,
    16'd47127, 16'd44879, 16'd42557, 16'd40190, 16'd37805,
    16'd35429, 16'd33087, 16'd30802, 16'd28594, 16'd26477,
    16'd24464, 16'd22562, 16'd20778, 16'd19111, 16'd17562,
    16'd16129, 16'd14807, 16'd13591, 16'd12475, 16'd11453,
    16'd10519, 16'd9665,  16'd8887,  16'd8176,  16'd7529,
    16'd6939,  16'd6401,  16'd5910,  16'd5462,  16'd5054,
    16'd4681,  16'd4340,  16'd4028,  16'd3743,  16'd3482,
    16'd3242,  16'd3022,  16'd2820,  16'd2635,  16'd2464,
    16'd2307,  16'd2162,  16'd2028,  16'd1904,  16'd1790
  };

  localparam logic [SUM_W-1:0] ROM_FIRST = CAL_ROM[0];
  localparam logic [SUM_W-1:0] ROM_LAST  = CAL_ROM[TABLE_ENTRIES-1];

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
  } conv_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TEMP_W-1:0] temp;
  } conv_rsp_t;

  function automatic logic [SUM_W-1:0] cal_rom(input logic [IDX_W-1:0] idx);
    logic [SUM_W-1:0] val;
    val = '0;
    if (int'(idx) < TABLE_ENTRIES) begin
      val = CAL_ROM[idx];
    end
    return val;
  endfunction

  function automatic logic [TEMP_W-1:0] point_temp(input logic [IDX_W-1:0] idx);
    return TEMP_W'(TEMP_START + TEMP_STEP * int'(idx));
  endfunction

endpackage

FILE: hdl/ntct_if.sv
// ----------------------------------------------------------------------------
// NTC table temperature channels
// Valid/ready channels for the sample input and the temperature result.
// ----------------------------------------------------------------------------
interface ntct_sample_if import ntct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ntct_result_if import ntct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temperature_tenths;

  modport source (output valid, output temperature_tenths, input ready);
  modport sink   (input valid, input temperature_tenths, output ready);
endinterface

FILE: hdl/ntct_accum.sv
// ----------------------------------------------------------------------------
// NTC table temperature batch accumulator
// Sums samples over one batch and requests a conversion on the last one.
// ----------------------------------------------------------------------------
module ntct_accum import ntct_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                batch_last,
  output conv_req_t           req
);

  logic [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0] sample_sum_next;
  logic [CNT_W-1:0] sample_count;

  assign sample_sum_next = sample_sum + SUM_W'(sample);
  assign batch_last      = (sample_count == CNT_W'(SAMPLES_PER_RESULT - 1));

  assign req.start = accept && batch_last;
  assign req.sum   = sample_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (batch_last) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sample_sum_next;
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/ntct_sub.sv
// ----------------------------------------------------------------------------
// NTC table temperature shared subtractor
// The one compare and subtract unit shared by the search, interpolation and division steps.
// ----------------------------------------------------------------------------
module ntct_sub import ntct_pkg::*; (
  input  logic [UNIT_W-1:0] a,
  input  logic [UNIT_W-1:0] b,
  output logic [UNIT_W-1:0] diff,
  output logic              borrow
);

  // Borrow set means a is less than b.
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

FILE: hdl/ntct_conv.sv
// ----------------------------------------------------------------------------
// NTC table temperature converter
// Sequencer for range check, table search, rounded interpolation and restoring division.
// ----------------------------------------------------------------------------
module ntct_conv import ntct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  conv_req_t req,
  output conv_rsp_t rsp
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_SEARCH = 10'b0000000100,
    S_EXACT  = 10'b0000001000,
    S_SPAN   = 10'b0000010000,
    S_OFFS   = 10'b0000100000,
    S_SCALE  = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_RESULT = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t             state;
  logic [SUM_W-1:0]   sum;
  logic [IDX_W-1:0]   lo;
  logic [IDX_W-1:0]   hi;
  logic [SUM_W-1:0]   vd;
  logic [NUM_W-1:0]   rem;
  logic [NUM_W-1:0]   dsh;
  logic [Q_W-1:0]     quo;
  logic [STEP_W-1:0]  step;
  logic [TEMP_W-1:0]  temp;

  logic [IDX_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid;
  logic               span_open;
  logic [SUM_W-1:0]   rom_mid;
  logic [SUM_W-1:0]   rom_lo;
  logic [SUM_W-1:0]   rom_hi;
  logic [UNIT_W-1:0]  op_a;
  logic [UNIT_W-1:0]  op_b;
  logic [UNIT_W-1:0]  diff;
  logic               borrow;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[IDX_W:1];
  assign span_open = ((hi - lo) > IDX_W'(1));
  assign rom_mid   = cal_rom(mid);
  assign rom_lo    = cal_rom(lo);
  assign rom_hi    = cal_rom(hi);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_SEARCH: begin
        op_a = UNIT_W'(rom_mid);
        op_b = UNIT_W'(sum);
      end
      S_EXACT: begin
        op_a = UNIT_W'(rom_lo);
        op_b = UNIT_W'(sum);
      end
      S_SPAN: begin
        op_a = UNIT_W'(rom_lo);
        op_b = UNIT_W'(rom_hi);
      end
      S_OFFS: begin
        op_a = UNIT_W'(sum);
        op_b = UNIT_W'(rom_hi);
      end
      S_DIV: begin
        op_a = rem;
        op_b = dsh;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ntct_sub u_sub (
    .a      (op_a),
    .b      (op_b),
    .diff   (diff),
    .borrow (borrow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            sum   <= req.sum;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Sums at or beyond either end of the table are settled here.
          if (sum < ROM_LAST) begin
            temp  <= TEMP_UNDER;
            state <= S_FINISH;
          end else if (sum == ROM_LAST) begin
            temp  <= point_temp(IDX_W'(TABLE_ENTRIES - 1));
            state <= S_FINISH;
          end else if (sum > ROM_FIRST) begin
            temp  <= TEMP_OVER;
            state <= S_FINISH;
          end else if (sum == ROM_FIRST) begin
            temp  <= point_temp(IDX_W'(0));
            state <= S_FINISH;
          end else begin
            lo    <= '0;
            hi    <= IDX_W'(TABLE_ENTRIES - 1);
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (span_open) begin
            if (borrow) begin
              hi <= mid;
            end else begin
              lo <= mid;
            end
          end else begin
            state <= S_EXACT;
          end
        end
        S_EXACT: begin
          if (diff == '0) begin
            temp  <= point_temp(lo);
            state <= S_FINISH;
          end else begin
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          vd    <= diff[SUM_W-1:0];
          state <= S_OFFS;
        end
        S_OFFS: begin
          if (vd == '0) begin
            temp  <= point_temp(hi);
            state <= S_FINISH;
          end else begin
            rem   <= diff;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          // Numerator of the rounded interpolation; the divisor starts at
          // the weight of the top quotient bit.
          rem   <= NUM_W'(rem[SUM_W-1:0]) * NUM_W'(TEMP_STEP) + NUM_W'(vd >> 1);
          dsh   <= NUM_W'(vd) << (Q_W - 1);
          quo   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!borrow) begin
            rem <= diff;
          end
          quo  <= {quo[Q_W-2:0], !borrow};
          dsh  <= dsh >> 1;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(Q_W - 1)) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          temp  <= point_temp(hi) - TEMP_W'(quo);
          state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.busy = (state != S_IDLE);
  assign rsp.done = (state == S_FINISH);
  assign rsp.temp = temp;

endmodule

FILE: hdl/ntc_table_temperature.sv
// ----------------------------------------------------------------------------
// NTC table temperature
// Batches thermistor samples and turns each batch sum into tenths of a degree.
// ----------------------------------------------------------------------------
// Each accepted word is one 10-bit converter sample. Samples are summed in
// batches of 64; the 64th sample of a batch starts a conversion and yields one
// temperature word, all others yield nothing. The first 63 samples of a batch
// are taken at one per cycle. The 64th starts a conversion that holds the
// input off until it is done: one range check, up to seven binary-search
// steps over the 60-entry calibration table, four set-up steps, six
// restoring-division steps and two to finish; the search and division
// steps and three set-up steps share one subtractor. A finished temperature
// waits in the output register; the input keeps taking samples meanwhile,
// and only the 64th sample of the next batch waits until that one is taken.
`include "ntc_table_temperature_macros.svh"

module ntc_table_temperature import ntct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ntct_sample_if.sink          sample_ch,
  ntct_result_if.source        result_ch
);

  logic              sample_accept;
  logic              batch_last;
  conv_req_t         conv_req;
  conv_rsp_t         conv_rsp;
  logic              out_valid;
  logic [TEMP_W-1:0] out_temp;

  assign sample_ch.ready = !conv_rsp.busy && !(batch_last && out_valid);
  assign sample_accept   = sample_ch.valid && sample_ch.ready;

  ntct_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .accept     (sample_accept),
    .sample     (sample_ch.adc_sample),
    .batch_last (batch_last),
    .req        (conv_req)
  );

  ntct_conv u_conv (
    .clk (clk),
    .rst (rst),
    .req (conv_req),
    .rsp (conv_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (conv_rsp.done) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_rsp.done) begin
      out_temp <= conv_rsp.temp;
    end
  end

  assign result_ch.valid              = out_valid;
  assign result_ch.temperature_tenths = out_temp;

  `NTCT_ASSERT_PROP(a_result_from_conv, $rose(result_ch.valid) |-> $past(conv_rsp.done))
  `NTCT_ASSERT_NEVER(a_no_accept_busy, sample_accept && conv_rsp.busy)
  `NTCT_ASSERT_NEVER(a_no_start_pending, conv_req.start && out_valid)
  `NTCT_ASSERT_PROP(a_temp_range, result_ch.valid |-> (result_ch.temperature_tenths <= TEMP_OVER))

endmodule

FILE: verif/ntct_temp_watch.sv
// ----------------------------------------------------------------------------
// NTC table temperature result watch
// Follows both channels, predicts each batch temperature and checks the result.
// ----------------------------------------------------------------------------
module ntct_temp_watch import ntct_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  ntct_sample_if smp,
  ntct_result_if res,
  output int     failures,
  output int     outstanding
);

  logic [SUM_W-1:0]  batch_sum   = '0;
  logic [CNT_W-1:0]  batch_count = '0;
  logic [TEMP_W-1:0] expected_temps [$];
  int                mismatch_count = 0;

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  // Temperature of a batch sum: a search over the descending calibration
  // table followed by a rounded interpolation back from the upper point.
  function automatic logic [TEMP_W-1:0] batch_temperature(input logic [SUM_W-1:0] sum);
    int lo;
    int hi;
    int mid;
    int upper_val;
    int span;
    int temp;
    lo = 0;
    hi = TABLE_ENTRIES - 1;
    if (sum < ROM_LAST) return TEMP_UNDER;
    if (sum == ROM_LAST) return TEMP_W'(TEMP_START + TEMP_STEP * hi);
    if (sum > ROM_FIRST) return TEMP_OVER;
    if (sum == ROM_FIRST) return TEMP_W'(TEMP_START);
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (int'(sum) > int'(CAL_ROM[mid])) hi = mid;
      else lo = mid;
    end
    if (int'(sum) >= int'(CAL_ROM[lo])) return TEMP_W'(TEMP_START + TEMP_STEP * lo);
    upper_val = int'(CAL_ROM[hi]);
    span      = int'(CAL_ROM[lo]) - upper_val;
    temp      = TEMP_START + TEMP_STEP * hi;
    if (span != 0) begin
      temp -= (TEMP_STEP * (int'(sum) - upper_val) + span / 2) / span;
    end
    return TEMP_W'(temp);
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    logic [TEMP_W-1:0] want;
    if (rst) begin
      batch_sum   = '0;
      batch_count = '0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_temps.size() == 0) begin
          note_mismatch("temperature word with none expected", -1,
                        int'(res.temperature_tenths));
        end else begin
          want = expected_temps.pop_front();
          if (res.temperature_tenths !== want) begin
            note_mismatch("temperature_tenths", int'(want), int'(res.temperature_tenths));
          end
        end
      end
      if (smp.valid && smp.ready) begin
        batch_sum = batch_sum + SUM_W'(smp.adc_sample);
        if (batch_count == CNT_W'(SAMPLES_PER_RESULT - 1)) begin
          expected_temps.push_back(batch_temperature(batch_sum));
          batch_sum   = '0;
          batch_count = '0;
        end else begin
          batch_count = batch_count + CNT_W'(1);
        end
      end
    end
    failures    <= mismatch_count;
    outstanding <= expected_temps.size();
  end

endmodule

FILE: verif/ntc_table_temperature_test.sv
// ----------------------------------------------------------------------------
// NTC table temperature testbench
// Feeds batches of converter samples aimed at chosen sums, with random idling
// on both channels, and leaves the checking to the result watch.
// ----------------------------------------------------------------------------
module ntc_table_temperature_test;
  import ntct_pkg::*;

  localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int MAX_SUM     = SAMPLES_PER_RESULT * SAMPLE_MAX;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {AIM_ENTRY, AIM_NEAR_ENTRY, AIM_BRACKET, AIM_SPAN, AIM_NOISE} aim_t;
  typedef enum int {PH_FREE, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH, PH_BACKLOG} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle    = 0;
  int   recv_stall   = 0;
  int   hold_request = 0;
  int   cycles       = 0;
  int   watch_failures;
  int   watch_outstanding;

  ntct_sample_if smp ();
  ntct_result_if res ();

  ntc_table_temperature DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (smp),
    .result_ch (res)
  );

  ntct_temp_watch watch (
    .clk         (clk),
    .rst         (rst),
    .smp         (smp),
    .res         (res),
    .failures    (watch_failures),
    .outstanding (watch_outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ntc_table_temperature_test NOT OK");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic offer_sample(input int value);
    while ($urandom_range(99) < send_idle) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid      <= 1'b1;
    smp.adc_sample <= SAMPLE_W'(value);
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
  endtask

  // One batch whose samples are random but add up to the given sum.
  task automatic offer_batch(input int target);
    int left;
    int lo_v;
    int hi_v;
    int v;
    left = target;
    for (int i = 0; i < SAMPLES_PER_RESULT; i++) begin
      hi_v = (left < SAMPLE_MAX) ? left : SAMPLE_MAX;
      lo_v = left - SAMPLE_MAX * (SAMPLES_PER_RESULT - 1 - i);
      if (lo_v < 0) lo_v = 0;
      v = $urandom_range(hi_v, lo_v);
      left -= v;
      offer_sample(v);
    end
  endtask

  task automatic offer_random_batch();
    aim_t aim;
    int   idx;
    int   target;
    aim = aim_t'($urandom_range(AIM_NOISE));
    idx = $urandom_range(TABLE_ENTRIES - 1);
    target = int'(CAL_ROM[idx]);
    case (aim)
      AIM_NEAR_ENTRY: begin
        target = target + $urandom_range(6) - 3;
      end
      AIM_BRACKET: begin
        if (idx < TABLE_ENTRIES - 1) begin
          target = $urandom_range(int'(CAL_ROM[idx]), int'(CAL_ROM[idx + 1]));
        end
      end
      AIM_SPAN: begin
        target = $urandom_range(int'(ROM_FIRST) + 64, int'(ROM_LAST) - 64);
      end
      default: begin
      end
    endcase
    if (aim == AIM_NOISE) begin
      for (int i = 0; i < SAMPLES_PER_RESULT; i++) offer_sample($urandom_range(SAMPLE_MAX));
    end else begin
      offer_batch(target);
    end
  endtask

  initial begin
    int directed_sums [10];
    directed_sums = '{0, MAX_SUM, int'(ROM_LAST) - 1, int'(ROM_LAST), int'(ROM_FIRST),
                      int'(ROM_FIRST) + 1, int'(CAL_ROM[30]), int'(CAL_ROM[30]) + 1,
                      (int'(CAL_ROM[10]) + int'(CAL_ROM[11])) / 2,
                      int'(CAL_ROM[TABLE_ENTRIES - 2]) - 1};
    smp.valid      = 1'b0;
    smp.adc_sample = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Table ends, exact entries and a plain interpolation, with no idling.
    foreach (directed_sums[i]) offer_batch(directed_sums[i]);

    for (int p = PH_FREE; p <= PH_BACKLOG; p++) begin
      case (phase_t'(p))
        PH_FREE:           begin send_idle = 0;  recv_stall = 0;  end
        PH_SENDER_IDLE:    begin send_idle = 88; recv_stall = 0;  end
        PH_RECEIVER_STALL: begin send_idle = 0;  recv_stall = 88; end
        PH_BOTH:           begin send_idle = 21; recv_stall = 21; end
        default: begin
          // The result is held back while words keep coming, so that the
          // next batch's last sample has to wait at the input.
          send_idle    = 0;
          recv_stall   = 0;
          hold_request = HOLD_CYCLES;
        end
      endcase
      repeat (4) offer_random_batch();
    end

    smp.valid  <= 1'b0;
    recv_stall = 0;
    @(posedge clk);
    while (watch_outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (watch_failures == 0 && watch_outstanding == 0) begin
      $display("ntc_table_temperature_test OK");
    end else begin
      $display("ntc_table_temperature_test NOT OK");
    end
    $finish;
  end

endmodule
